FILE: rtl/core/lsect_pkg.sv
// Shared types, constants and the threshold ROM of the log-spaced event count trigger.
// Used by every module of the block; no dependencies of its own.
`timescale 1ns / 1ps

package lsect_pkg;

    // Counter and field widths
    localparam int COUNT_WIDTH      = 40;
    localparam int STEPS_PER_DECADE = 20;
    localparam int DEF_MAX_BASES    = 4;
    localparam int DIM_W            = 16;
    localparam int BASE_W           = 10;
    localparam int BCOUNT_W         = 3;
    localparam int CNT_EFF_W        = 4;
    localparam int NUM_BASE_REGS    = 4;

    // Configuration port
    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 16;

    typedef enum logic [CFG_INDEX_W-1:0] {
        CFG_DIMENSION = 3'd0,
        CFG_NUM_BASES = 3'd1,
        CFG_BASE_0    = 3'd2,
        CFG_BASE_1    = 3'd3,
        CFG_BASE_2    = 3'd4,
        CFG_BASE_3    = 3'd5
    } cfg_idx_t;

    // Second schedule product split: base*dimension times the scale in two halves
    localparam int PROD_W = BASE_W + DIM_W;
    localparam int LO_W   = COUNT_WIDTH / 2;
    localparam int HI_W   = COUNT_WIDTH - LO_W;
    localparam int PP_W   = PROD_W + HI_W;
    localparam int FULL_W = PROD_W + COUNT_WIDTH;

    // First schedule ROM: distinct floor(10^(k/20)) below 2^40, k = 0 .. 240
    localparam int FIRST_ROM_DEPTH = 229;
    localparam int FIRST_IDX_W     = $clog2(FIRST_ROM_DEPTH);
    localparam logic [FIRST_IDX_W-1:0] FIRST_LAST = FIRST_IDX_W'(FIRST_ROM_DEPTH - 1);

    localparam logic [COUNT_WIDTH-1:0] FIRST_ROM [FIRST_ROM_DEPTH] = '{
        40'd1, 40'd2, 40'd3, 40'd4, 40'd5, 40'd6, 40'd7, 40'd8,
        40'd10, 40'd11, 40'd12, 40'd14, 40'd15, 40'd17, 40'd19, 40'd22, 40'd25, 40'd28,
        40'd31, 40'd35, 40'd39, 40'd44, 40'd50, 40'd56, 40'd63, 40'd70, 40'd79, 40'd89,
        40'd100, 40'd112, 40'd125, 40'd141, 40'd158, 40'd177, 40'd199, 40'd223,
        40'd251, 40'd281, 40'd316, 40'd354, 40'd398, 40'd446, 40'd501, 40'd562,
        40'd630, 40'd707, 40'd794, 40'd891,
        40'd1000, 40'd1122, 40'd1258, 40'd1412, 40'd1584, 40'd1778, 40'd1995, 40'd2238,
        40'd2511, 40'd2818, 40'd3162, 40'd3548, 40'd3981, 40'd4466, 40'd5011, 40'd5623,
        40'd6309, 40'd7079, 40'd7943, 40'd8912,
        40'd10000, 40'd11220, 40'd12589, 40'd14125, 40'd15848, 40'd17782, 40'd19952,
        40'd22387, 40'd25118, 40'd28183, 40'd31622, 40'd35481, 40'd39810, 40'd44668,
        40'd50118, 40'd56234, 40'd63095, 40'd70794, 40'd79432, 40'd89125,
        40'd100000, 40'd112201, 40'd125892, 40'd141253, 40'd158489, 40'd177827,
        40'd199526, 40'd223872, 40'd251188, 40'd281838, 40'd316227, 40'd354813,
        40'd398107, 40'd446683, 40'd501187, 40'd562341, 40'd630957, 40'd707945,
        40'd794328, 40'd891250,
        40'd1000000, 40'd1122018, 40'd1258925, 40'd1412537, 40'd1584893, 40'd1778279,
        40'd1995262, 40'd2238721, 40'd2511886, 40'd2818382, 40'd3162277, 40'd3548133,
        40'd3981071, 40'd4466835, 40'd5011872, 40'd5623413, 40'd6309573, 40'd7079457,
        40'd7943282, 40'd8912509,
        40'd10000000, 40'd11220184, 40'd12589254, 40'd14125375, 40'd15848931,
        40'd17782794, 40'd19952623, 40'd22387211, 40'd25118864, 40'd28183829,
        40'd31622776, 40'd35481338, 40'd39810717, 40'd44668359, 40'd50118723,
        40'd56234132, 40'd63095734, 40'd70794578, 40'd79432823, 40'd89125093,
        40'd100000000, 40'd112201845, 40'd125892541, 40'd141253754, 40'd158489319,
        40'd177827941, 40'd199526231, 40'd223872113, 40'd251188643, 40'd281838293,
        40'd316227766, 40'd354813389, 40'd398107170, 40'd446683592, 40'd501187233,
        40'd562341325, 40'd630957344, 40'd707945784, 40'd794328234, 40'd891250938,
        40'd1000000000, 40'd1122018454, 40'd1258925411, 40'd1412537544, 40'd1584893192,
        40'd1778279410, 40'd1995262314, 40'd2238721138, 40'd2511886431, 40'd2818382931,
        40'd3162277660, 40'd3548133892, 40'd3981071705, 40'd4466835921, 40'd5011872336,
        40'd5623413251, 40'd6309573444, 40'd7079457843, 40'd7943282347, 40'd8912509381,
        40'd10000000000, 40'd11220184543, 40'd12589254117, 40'd14125375446,
        40'd15848931924, 40'd17782794100, 40'd19952623149, 40'd22387211385,
        40'd25118864315, 40'd28183829312, 40'd31622776601, 40'd35481338923,
        40'd39810717055, 40'd44668359215, 40'd50118723362, 40'd56234132519,
        40'd63095734448, 40'd70794578438, 40'd79432823472, 40'd89125093813,
        40'd100000000000, 40'd112201845430, 40'd125892541179, 40'd141253754462,
        40'd158489319246, 40'd177827941003, 40'd199526231496, 40'd223872113856,
        40'd251188643150, 40'd281838293126, 40'd316227766016, 40'd354813389233,
        40'd398107170553, 40'd446683592150, 40'd501187233627, 40'd562341325190,
        40'd630957344480, 40'd707945784384, 40'd794328234724, 40'd891250938133,
        40'd1000000000000
    };

    // Read the threshold ROM; unused addresses read as all ones
    function automatic logic [COUNT_WIDTH-1:0] first_rom(input logic [FIRST_IDX_W-1:0] idx);
        logic [COUNT_WIDTH-1:0] val;
        val = '1;
        if (idx <= FIRST_LAST)
        begin
            val = FIRST_ROM[idx];
        end
        return val;
    endfunction

    // Reset value of base register i
    function automatic logic [BASE_W-1:0] base_reset(input int i);
        logic [BASE_W-1:0] val;
        unique case (i)
            0:       val = BASE_W'(1);
            1:       val = BASE_W'(2);
            2:       val = BASE_W'(5);
            3:       val = BASE_W'(10);
            default: val = BASE_W'(1);
        endcase
        return val;
    endfunction

    // Controller to datapath commands
    typedef struct packed {
        logic load_in;
        logic calc_prod;
        logic calc_lo;
        logic calc_hi;
        logic calc_sum;
        logic commit;
    } lsect_cmd_t;

    // Datapath to controller status
    typedef struct packed {
        logic out_full;
    } lsect_status_t;

endpackage

FILE: rtl/core/log_spaced_event_count_trigger.sv
// Top level of the log-spaced event count trigger.
// Depends on lsect_pkg, lsect_regs, lsect_ctrl and lsect_dp.
//
// Usage:
//   Input channel (in_valid / in_stall, event_count): one event count per item.
//   Output channel (out_valid / out_stall, fire, first_hit, second_hit): one
//   result per input item, in order.
//   Config channel (cfg_valid / cfg_ready, cfg_index, cfg_data): register writes,
//   always ready; write only while no item is in flight.
//   Each item runs through the product, two half-width scale multiplies, sum and
//   compare steps of the controller sequence before its result is registered; a new
//   item is accepted only once the controller has committed the last one.
//   A stalled result is held in the output register; the next item may be accepted
//   meanwhile and waits at its compare step until the register frees.
//   Reset: both schedules return to their first thresholds (1 and base_0*dimension),
//   configuration registers return to their defaults, no result is pending.
`timescale 1ns / 1ps

module log_spaced_event_count_trigger
    import lsect_pkg::*;
#(
    parameter int MAX_BASES = DEF_MAX_BASES
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [COUNT_WIDTH-1:0] event_count,
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic                   fire,
    output logic                   first_hit,
    output logic                   second_hit,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data
);

    localparam int POS_W = (MAX_BASES > 1) ? $clog2(MAX_BASES) : 1;

    lsect_cmd_t           cmd;
    lsect_status_t        status;
    logic [DIM_W-1:0]     dimension;
    logic [BASE_W-1:0]    base_sel;
    logic [CNT_EFF_W-1:0] count_eff;
    logic [POS_W-1:0]     base_position;

    lsect_regs #(
        .MAX_BASES (MAX_BASES),
        .POS_W     (POS_W)
    ) u_regs (
        .clk           (clk),
        .rst_n         (rst_n),
        .cfg_valid     (cfg_valid),
        .cfg_ready     (cfg_ready),
        .cfg_index     (cfg_index),
        .cfg_data      (cfg_data),
        .base_position (base_position),
        .dimension     (dimension),
        .base_sel      (base_sel),
        .count_eff     (count_eff)
    );

    lsect_ctrl u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .out_stall (out_stall),
        .status    (status),
        .cmd       (cmd)
    );

    lsect_dp #(
        .MAX_BASES (MAX_BASES),
        .POS_W     (POS_W)
    ) u_dp (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .status        (status),
        .event_count   (event_count),
        .dimension     (dimension),
        .base_sel      (base_sel),
        .count_eff     (count_eff),
        .base_position (base_position),
        .out_stall     (out_stall),
        .out_valid     (out_valid),
        .fire          (fire),
        .first_hit     (first_hit),
        .second_hit    (second_hit)
    );

endmodule

FILE: rtl/core/lsect_regs.sv
// Configuration registers: dimension, number of bases and the base multipliers.
// Depends on lsect_pkg.
`timescale 1ns / 1ps

module lsect_regs
    import lsect_pkg::*;
#(
    parameter int MAX_BASES = DEF_MAX_BASES,
    parameter int POS_W     = (MAX_BASES > 1) ? $clog2(MAX_BASES) : 1
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_valid,
    output logic                   cfg_ready,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic [POS_W-1:0]       base_position,
    output logic [DIM_W-1:0]       dimension,
    output logic [BASE_W-1:0]      base_sel,
    output logic [CNT_EFF_W-1:0]   count_eff
);

    logic [DIM_W-1:0]    dimension_reg;
    logic [BCOUNT_W-1:0] num_bases_reg;
    logic [BASE_W-1:0]   base_reg [MAX_BASES];
    logic                wr_en;
    logic [CNT_EFF_W-1:0] bc_wide;

    assign cfg_ready = 1'b1;
    assign wr_en     = cfg_valid & cfg_ready;

    // Scalar registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dimension_reg <= DIM_W'(1);
            num_bases_reg <= BCOUNT_W'(3);
        end
        else if (wr_en)
        begin
            if (cfg_index == CFG_DIMENSION)
            begin
                dimension_reg <= cfg_data[DIM_W-1:0];
            end
            if (cfg_index == CFG_NUM_BASES)
            begin
                num_bases_reg <= cfg_data[BCOUNT_W-1:0];
            end
        end
    end

    // Base multipliers; those beyond the register list keep their reset value
    for (genvar i = 0; i < MAX_BASES; i++)
    begin : g_base
        if (i < NUM_BASE_REGS)
        begin : g_wr
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    base_reg[i] <= base_reset(i);
                end
                else if (wr_en && cfg_index == CFG_INDEX_W'(int'(CFG_BASE_0) + i))
                begin
                    base_reg[i] <= cfg_data[BASE_W-1:0];
                end
            end
        end
        else
        begin : g_fixed
            always_ff @(posedge clk or negedge rst_n)
            begin
                if (!rst_n)
                begin
                    base_reg[i] <= base_reset(i);
                end
            end
        end
    end

    // Clamp the base count to 1 .. MAX_BASES
    assign bc_wide = CNT_EFF_W'(num_bases_reg);

    always_comb
    begin
        priority if (bc_wide == '0)
        begin
            count_eff = CNT_EFF_W'(1);
        end
        else if (bc_wide > CNT_EFF_W'(MAX_BASES))
        begin
            count_eff = CNT_EFF_W'(MAX_BASES);
        end
        else
        begin
            count_eff = bc_wide;
        end
    end

    assign dimension = dimension_reg;
    assign base_sel  = base_reg[base_position];

endmodule

FILE: rtl/core/lsect_ctrl.sv
// Controller state machine: sequences accept, multiply, sum and result commit.
// Depends on lsect_pkg.
`timescale 1ns / 1ps

module lsect_ctrl
    import lsect_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    input  logic          in_valid,
    output logic          in_stall,
    input  logic          out_stall,
    input  lsect_status_t status,
    output lsect_cmd_t    cmd
);

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_PROD = 6'b000010,
        ST_LO   = 6'b000100,
        ST_HI   = 6'b001000,
        ST_SUM  = 6'b010000,
        ST_EVAL = 6'b100000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   out_room;

    // Result register is free or drains this cycle
    assign out_room = !status.out_full || !out_stall;

    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE: if (in_valid) state_next = ST_PROD;
            ST_PROD: state_next = ST_LO;
            ST_LO:   state_next = ST_HI;
            ST_HI:   state_next = ST_SUM;
            ST_SUM:  state_next = ST_EVAL;
            ST_EVAL: if (out_room) state_next = ST_IDLE;
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    // Commands
    assign in_stall      = (state_reg != ST_IDLE);
    assign cmd.load_in   = (state_reg == ST_IDLE) && in_valid;
    assign cmd.calc_prod = (state_reg == ST_PROD);
    assign cmd.calc_lo   = (state_reg == ST_LO);
    assign cmd.calc_hi   = (state_reg == ST_HI);
    assign cmd.calc_sum  = (state_reg == ST_SUM);
    assign cmd.commit    = (state_reg == ST_EVAL) && out_room;

endmodule

FILE: rtl/core/lsect_dp.sv
// Datapath: both schedules' thresholds, split product, compares and result register.
// Depends on lsect_pkg.
`timescale 1ns / 1ps

module lsect_dp
    import lsect_pkg::*;
#(
    parameter int MAX_BASES = DEF_MAX_BASES,
    parameter int POS_W     = (MAX_BASES > 1) ? $clog2(MAX_BASES) : 1
)
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  lsect_cmd_t             cmd,
    output lsect_status_t          status,
    input  logic [COUNT_WIDTH-1:0] event_count,
    input  logic [DIM_W-1:0]       dimension,
    input  logic [BASE_W-1:0]      base_sel,
    input  logic [CNT_EFF_W-1:0]   count_eff,
    output logic [POS_W-1:0]       base_position,
    input  logic                   out_stall,
    output logic                   out_valid,
    output logic                   fire,
    output logic                   first_hit,
    output logic                   second_hit
);

    // Payload pipeline
    logic [COUNT_WIDTH-1:0] cnt_reg;
    logic [PROD_W-1:0]      prod_reg;
    logic [PP_W-1:0]        pp_lo_reg;
    logic [PP_W-1:0]        pp_hi_reg;
    logic [COUNT_WIDTH-1:0] thr2_reg;
    logic                   live2_reg;

    // Schedule state
    logic [FIRST_IDX_W-1:0] first_idx_reg;
    logic [FIRST_IDX_W-1:0] first_idx_next;
    logic [COUNT_WIDTH-1:0] first_thr_reg;
    logic [COUNT_WIDTH-1:0] first_thr_next;
    logic                   first_dead_reg;
    logic                   first_dead_next;
    logic [POS_W-1:0]       pos_reg;
    logic [POS_W-1:0]       pos_next;
    logic [COUNT_WIDTH-1:0] scale_reg;
    logic [COUNT_WIDTH-1:0] scale_next;

    // Result register
    logic out_valid_reg;
    logic fire_reg;
    logic first_hit_reg;
    logic second_hit_reg;

    logic                   hit1;
    logic                   hit2;
    logic [FULL_W-1:0]      full_sum;
    logic [COUNT_WIDTH+3:0] scale_x10;
    logic [CNT_EFF_W-1:0]   pos_inc;

    // Hold the item, then build base*dimension*scale over the two scale halves
    always_ff @(posedge clk)
    begin
        if (cmd.load_in)
        begin
            cnt_reg <= event_count;
        end
        if (cmd.calc_prod)
        begin
            prod_reg <= PROD_W'(base_sel) * PROD_W'(dimension);
        end
        if (cmd.calc_lo)
        begin
            pp_lo_reg <= PP_W'(prod_reg) * PP_W'(scale_reg[LO_W-1:0]);
        end
        if (cmd.calc_hi)
        begin
            pp_hi_reg <= PP_W'(prod_reg) * PP_W'(scale_reg[COUNT_WIDTH-1:LO_W]);
        end
        if (cmd.calc_sum)
        begin
            thr2_reg  <= full_sum[COUNT_WIDTH-1:0];
            live2_reg <= (scale_reg != '1) && (full_sum[FULL_W-1:COUNT_WIDTH] == '0);
        end
    end

    assign full_sum = FULL_W'(pp_lo_reg) + (FULL_W'(pp_hi_reg) << LO_W);

    // Compare both thresholds
    assign hit1 = !first_dead_reg && (cnt_reg >= first_thr_reg);
    assign hit2 = live2_reg && (cnt_reg >= thr2_reg);

    // Advance the first schedule by one ROM entry; stop after the last
    always_comb
    begin
        first_idx_next  = first_idx_reg;
        first_thr_next  = first_thr_reg;
        first_dead_next = first_dead_reg;
        if (cmd.commit && hit1)
        begin
            if (first_idx_reg == FIRST_LAST)
            begin
                first_dead_next = 1'b1;
            end
            else
            begin
                first_idx_next = first_idx_reg + 1'b1;
                first_thr_next = first_rom(first_idx_reg + 1'b1);
            end
        end
    end

    // Advance the second schedule: next base, or wrap and scale by ten (all ones on overflow)
    assign pos_inc   = CNT_EFF_W'(pos_reg) + CNT_EFF_W'(1);
    assign scale_x10 = (COUNT_WIDTH+4)'({scale_reg, 3'b000})
                     + (COUNT_WIDTH+4)'({scale_reg, 1'b0});

    always_comb
    begin
        pos_next   = pos_reg;
        scale_next = scale_reg;
        if (cmd.commit && hit2)
        begin
            if (pos_inc < count_eff)
            begin
                pos_next = pos_inc[POS_W-1:0];
            end
            else
            begin
                pos_next = '0;
                if (scale_x10[COUNT_WIDTH+3:COUNT_WIDTH] != '0)
                begin
                    scale_next = '1;
                end
                else
                begin
                    scale_next = scale_x10[COUNT_WIDTH-1:0];
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            first_idx_reg  <= '0;
            first_thr_reg  <= COUNT_WIDTH'(1);
            first_dead_reg <= 1'b0;
            pos_reg        <= '0;
            scale_reg      <= COUNT_WIDTH'(1);
        end
        else
        begin
            first_idx_reg  <= first_idx_next;
            first_thr_reg  <= first_thr_next;
            first_dead_reg <= first_dead_next;
            pos_reg        <= pos_next;
            scale_reg      <= scale_next;
        end
    end

    // Result register: load on commit, hold while stalled
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.commit)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            fire_reg       <= hit1 | hit2;
            first_hit_reg  <= hit1;
            second_hit_reg <= hit2;
        end
    end

    assign status.out_full = out_valid_reg;
    assign base_position   = pos_reg;
    assign out_valid       = out_valid_reg;
    assign fire            = fire_reg;
    assign first_hit       = first_hit_reg;
    assign second_hit      = second_hit_reg;

endmodule

FILE: rtl/core/lsect_checker.sv
// Port-level checker for the log-spaced event count trigger, bound to the top level.
// Depends on lsect_pkg.
`timescale 1ns / 1ps

module lsect_checker
    import lsect_pkg::*;
(
    input logic                   clk,
    input logic                   rst_n,
    input logic                   in_valid,
    input logic                   in_stall,
    input logic [COUNT_WIDTH-1:0] event_count,
    input logic                   out_valid,
    input logic                   out_stall,
    input logic                   fire,
    input logic                   first_hit,
    input logic                   second_hit
);

    // Fire is the OR of the two hit flags
    a_fire_or: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (fire == (first_hit | second_hit)))
        else $error("fire does not match the hit flags");

    // A stalled result holds
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid && out_stall) |=> (out_valid && $stable(fire)
            && $stable(first_hit) && $stable(second_hit)))
        else $error("stalled result changed");

    // A waiting item holds its count
    a_in_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && in_stall) |=> (in_valid && $stable(event_count)))
        else $error("stalled input item changed");

    // An accepted item keeps the input side busy
    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid && !in_stall) |=> in_stall)
        else $error("input accepted back to back");

    // A new result only comes out of a busy block
    a_result_from_work: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid) |-> $past(in_stall))
        else $error("result appeared with no item in flight");

endmodule

bind log_spaced_event_count_trigger lsect_checker u_lsect_checker (.*);
